[rtl/core/eag_pkg.sv]
// Shared types and constants for the effective address generator.
// Depends on nothing; imported by eag_calc and effective_address_generator.
package eag_pkg;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [1:0] READS_NONE = 2'd0;
    localparam logic [1:0] READS_ONE  = 2'd1;
    localparam logic [1:0] READS_TWO  = 2'd2;

    localparam logic ITEM_START = 1'b0;
    localparam logic ITEM_DATA  = 1'b1;

    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_FINAL   = 1'b1;

    typedef enum logic [4:0] {
        M_IMP   = 5'd0,  M_IMM   = 5'd1,  M_IMM8  = 5'd2,  M_IMM16 = 5'd3,
        M_IMMX  = 5'd4,  M_ACC   = 5'd5,  M_DP    = 5'd6,  M_DPI   = 5'd7,
        M_DPIL  = 5'd8,  M_DPX   = 5'd9,  M_DPY   = 5'd10, M_DPIX  = 5'd11,
        M_DPIY  = 5'd12, M_DPILY = 5'd13, M_REL   = 5'd14, M_RELL  = 5'd15,
        M_ABS   = 5'd16, M_ABSL  = 5'd17, M_ABSX  = 5'd18, M_ABSLX = 5'd19,
        M_ABSY  = 5'd20, M_ABSI  = 5'd21, M_ABSIL = 5'd22, M_ABSIX = 5'd23,
        M_SR    = 5'd24, M_SRY   = 5'd25, M_MOVE  = 5'd26
    } t_mode;

    typedef struct packed {
        logic        kind;
        logic [23:0] address;
        logic [1:0]  read_bytes;
        logic [15:0] immediate_value;
        logic [1:0]  pc_advance;
        logic        extra_cycle;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [1:0]  reads_pending;
        logic [4:0]  held_mode;
        logic [15:0] held_pointer_word;
        logic [15:0] held_index;
        logic [7:0]  held_bank;
        logic [1:0]  held_pc_advance;
        logic        held_extra_cycle;
    } t_state;

    typedef struct packed {
        logic        kind;
        logic [4:0]  mode;
        logic [23:0] operand_bytes;
        logic [15:0] direct_page;
        logic [15:0] index_x;
        logic [15:0] index_y;
        logic [15:0] stack_pointer;
        logic [7:0]  data_bank;
        logic [7:0]  program_bank;
        logic        index_narrow;
        logic        accum_narrow;
        logic [15:0] read_data;
    } t_item;

endpackage

[rtl/core/eag_calc.sv]
// Address and operand calculation for one input beat: results and next state.
// Depends on eag_pkg.
module eag_calc (
    input  eag_pkg::t_item   i_item,
    input  eag_pkg::t_state  i_state,
    output eag_pkg::t_state  o_state,
    output eag_pkg::t_result o_res0,
    output eag_pkg::t_result o_res1,
    output logic [1:0]       o_count
);
    import eag_pkg::*;

    logic [7:0]  op8;
    logic [15:0] op16;
    logic [15:0] mx;
    logic [15:0] my;
    logic        dpx;
    logic [15:0] dptr;
    logic [23:0] fbase;
    logic [23:0] fsum;
    logic [23:0] rbase;
    logic        held_long;
    t_mode       mode;

    assign mode  = t_mode'(i_item.mode);
    assign op8   = i_item.operand_bytes[7:0];
    assign op16  = i_item.operand_bytes[15:0];
    assign mx    = i_item.index_narrow ? {8'd0, i_item.index_x[7:0]} : i_item.index_x;
    assign my    = i_item.index_narrow ? {8'd0, i_item.index_y[7:0]} : i_item.index_y;
    assign dpx   = (i_item.direct_page[7:0] != 8'd0);
    assign dptr  = {8'd0, op8} + i_item.direct_page;
    assign fbase = {i_item.data_bank, op16};
    assign fsum  = fbase + {8'd0, (mode == M_ABSX) ? mx : my};

    assign held_long = (i_state.held_mode == 5'(M_DPIL)) ||
                       (i_state.held_mode == 5'(M_DPILY)) ||
                       (i_state.held_mode == 5'(M_ABSIL));
    assign rbase = held_long ? {i_item.read_data[7:0], i_state.held_pointer_word}
                             : {i_state.held_bank, i_item.read_data};

    always_comb begin
        o_state = i_state;
        o_res0  = '0;
        o_res1  = '0;
        o_count = 2'd0;
        if (i_item.kind == ITEM_DATA) begin
            if (i_state.reads_pending == READS_TWO) begin
                o_state.held_pointer_word = i_item.read_data;
                o_state.reads_pending     = READS_ONE;
            end else if (i_state.reads_pending != READS_NONE) begin
                o_state.reads_pending = READS_NONE;
                o_res0.kind        = KIND_FINAL;
                o_res0.address     = rbase + {8'd0, i_state.held_index};
                o_res0.pc_advance  = i_state.held_pc_advance;
                o_res0.extra_cycle = i_state.held_extra_cycle;
                o_res0.last        = 1'b1;
                o_count            = 2'd1;
            end
        end else begin
            o_state.reads_pending = READS_NONE;
            o_count     = 2'd1;
            o_res0.last = 1'b1;
            o_res0.kind = KIND_FINAL;
            case (mode)
                M_IMP: begin
                    o_res0.extra_cycle = 1'b1;
                end
                M_IMM: begin
                    o_res0.immediate_value = i_item.accum_narrow ? {8'd0, op8} : op16;
                    o_res0.pc_advance      = i_item.accum_narrow ? 2'd1 : 2'd2;
                end
                M_IMM8, M_REL: begin
                    o_res0.immediate_value = {8'd0, op8};
                    o_res0.pc_advance      = 2'd1;
                end
                M_IMM16, M_RELL: begin
                    o_res0.immediate_value = op16;
                    o_res0.pc_advance      = 2'd2;
                end
                M_IMMX: begin
                    o_res0.immediate_value = i_item.index_narrow ? {8'd0, op8} : op16;
                    o_res0.pc_advance      = i_item.index_narrow ? 2'd1 : 2'd2;
                end
                M_DP: begin
                    o_res0.address     = {8'd0, dptr};
                    o_res0.pc_advance  = 2'd1;
                    o_res0.extra_cycle = dpx;
                end
                M_DPX, M_DPY: begin
                    o_res0.address     = {8'd0, dptr + ((mode == M_DPX) ? mx : my)};
                    o_res0.pc_advance  = 2'd1;
                    o_res0.extra_cycle = dpx;
                end
                M_ABS: begin
                    o_res0.address    = fbase;
                    o_res0.pc_advance = 2'd2;
                end
                M_ABSL: begin
                    o_res0.address    = i_item.operand_bytes;
                    o_res0.pc_advance = 2'd3;
                end
                M_ABSX, M_ABSY: begin
                    o_res0.address     = fsum;
                    o_res0.pc_advance  = 2'd2;
                    o_res0.extra_cycle = (fsum[15:8] != fbase[15:8]);
                end
                M_ABSLX: begin
                    o_res0.address    = i_item.operand_bytes + {8'd0, mx};
                    o_res0.pc_advance = 2'd3;
                end
                M_SR: begin
                    o_res0.address     = {8'd0, {8'd0, op8} + i_item.stack_pointer};
                    o_res0.pc_advance  = 2'd1;
                    o_res0.extra_cycle = 1'b1;
                end
                M_DPI, M_DPIX, M_DPIY: begin
                    o_state = '{reads_pending: READS_ONE, held_mode: i_item.mode,
                                held_pointer_word: 16'd0,
                                held_index: (mode == M_DPIY) ? my : 16'd0,
                                held_bank: i_item.data_bank, held_pc_advance: 2'd1,
                                held_extra_cycle: dpx};
                    o_res0.kind       = KIND_REQUEST;
                    o_res0.address    = {8'd0, dptr + ((mode == M_DPIX) ? mx : 16'd0)};
                    o_res0.read_bytes = 2'd2;
                end
                M_DPIL, M_DPILY: begin
                    o_state = '{reads_pending: READS_TWO, held_mode: i_item.mode,
                                held_pointer_word: 16'd0,
                                held_index: (mode == M_DPILY) ? my : 16'd0,
                                held_bank: 8'd0, held_pc_advance: 2'd1,
                                held_extra_cycle: dpx};
                    o_count           = 2'd2;
                    o_res0.kind       = KIND_REQUEST;
                    o_res0.address    = {8'd0, dptr};
                    o_res0.read_bytes = 2'd2;
                    o_res0.last       = 1'b0;
                    o_res1.kind       = KIND_REQUEST;
                    o_res1.address    = {8'd0, dptr + 16'd2};
                    o_res1.read_bytes = 2'd1;
                    o_res1.last       = 1'b1;
                end
                M_ABSI: begin
                    o_state = '{reads_pending: READS_ONE, held_mode: i_item.mode,
                                held_pointer_word: 16'd0, held_index: 16'd0,
                                held_bank: 8'd0, held_pc_advance: 2'd2,
                                held_extra_cycle: 1'b0};
                    o_res0.kind       = KIND_REQUEST;
                    o_res0.address    = {8'd0, op16};
                    o_res0.read_bytes = 2'd2;
                end
                M_ABSIL: begin
                    o_state = '{reads_pending: READS_TWO, held_mode: i_item.mode,
                                held_pointer_word: 16'd0, held_index: 16'd0,
                                held_bank: 8'd0, held_pc_advance: 2'd2,
                                held_extra_cycle: 1'b0};
                    o_count           = 2'd2;
                    o_res0.kind       = KIND_REQUEST;
                    o_res0.address    = {8'd0, op16};
                    o_res0.read_bytes = 2'd2;
                    o_res0.last       = 1'b0;
                    o_res1.kind       = KIND_REQUEST;
                    o_res1.address    = {8'd0, op16 + 16'd2};
                    o_res1.read_bytes = 2'd1;
                    o_res1.last       = 1'b1;
                end
                M_ABSIX: begin
                    o_state = '{reads_pending: READS_ONE, held_mode: i_item.mode,
                                held_pointer_word: 16'd0, held_index: 16'd0,
                                held_bank: i_item.program_bank, held_pc_advance: 2'd2,
                                held_extra_cycle: 1'b0};
                    o_res0.kind       = KIND_REQUEST;
                    o_res0.address    = {i_item.program_bank, op16} + {8'd0, mx};
                    o_res0.read_bytes = 2'd2;
                end
                M_SRY: begin
                    o_state = '{reads_pending: READS_ONE, held_mode: i_item.mode,
                                held_pointer_word: 16'd0, held_index: my,
                                held_bank: i_item.data_bank, held_pc_advance: 2'd1,
                                held_extra_cycle: 1'b1};
                    o_res0.kind       = KIND_REQUEST;
                    o_res0.address    = {8'd0, {8'd0, op8} + i_item.stack_pointer};
                    o_res0.read_bytes = 2'd2;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

[rtl/core/effective_address_generator.sv]
// Effective address generator: operand decode, pointer read requests, final address.
// Result beats are registered: each is written into the output queue as its input beat is accepted.
// Throughput: one input beat per cycle while o_in_stall is low; two-read modes queue two result beats.
// Results wait in a four-entry output queue; input stalls while it holds three or more.
// Reset (synchronous, active low) clears the held operation state and empties the queue.
// Depends on eag_pkg and eag_calc.
module effective_address_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_item_kind,
    input  logic [4:0]  i_mode,
    input  logic [23:0] i_operand_bytes,
    input  logic [15:0] i_direct_page,
    input  logic [15:0] i_index_x,
    input  logic [15:0] i_index_y,
    input  logic [15:0] i_stack_pointer,
    input  logic [7:0]  i_data_bank,
    input  logic [7:0]  i_program_bank,
    input  logic        i_index_narrow,
    input  logic        i_accum_narrow,
    input  logic [15:0] i_read_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_result_kind,
    output logic [23:0] o_address,
    output logic [1:0]  o_read_bytes,
    output logic [15:0] o_immediate_value,
    output logic [1:0]  o_pc_advance,
    output logic        o_extra_cycle,
    output logic        o_last
);
    import eag_pkg::*;

    t_item                  item;
    t_state                 r_state;
    t_state                 n_state;
    t_result                res0;
    t_result                res1;
    logic [1:0]             res_count;
    t_result                r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     r_wr_ptr;
    logic [FIFO_AW-1:0]     r_rd_ptr;
    logic [FIFO_AW:0]       r_count;
    logic                   in_fire;
    logic                   out_fire;
    logic [1:0]             push;
    t_result                head;

    assign item = '{kind: i_item_kind, mode: i_mode, operand_bytes: i_operand_bytes,
                    direct_page: i_direct_page, index_x: i_index_x, index_y: i_index_y,
                    stack_pointer: i_stack_pointer, data_bank: i_data_bank,
                    program_bank: i_program_bank, index_narrow: i_index_narrow,
                    accum_narrow: i_accum_narrow, read_data: i_read_data};

    eag_calc u_calc (
        .i_item  (item),
        .i_state (r_state),
        .o_state (n_state),
        .o_res0  (res0),
        .o_res1  (res1),
        .o_count (res_count)
    );

    assign o_in_stall = (r_count > (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign in_fire    = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_count != '0);
    assign out_fire   = o_out_valid && !i_out_stall;
    assign push       = in_fire ? res_count : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (in_fire) begin
                r_state <= n_state;
            end
            r_wr_ptr <= r_wr_ptr + FIFO_AW'(push);
            if (out_fire) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_count <= r_count + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(out_fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push != 2'd0) begin
            r_mem[r_wr_ptr] <= res0;
        end
        if (push == 2'd2) begin
            r_mem[r_wr_ptr + FIFO_AW'(1)] <= res1;
        end
    end

    assign head              = r_mem[r_rd_ptr];
    assign o_result_kind     = head.kind;
    assign o_address         = head.address;
    assign o_read_bytes      = head.read_bytes;
    assign o_immediate_value = head.immediate_value;
    assign o_pc_advance      = head.pc_advance;
    assign o_extra_cycle     = head.extra_cycle;
    assign o_last            = head.last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("output queue overflow");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        FIFO_AW'(r_wr_ptr - r_rd_ptr) == r_count[FIFO_AW-1:0])
        else $error("queue pointers disagree with count");

    a_pending_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.reads_pending != 2'd3)
        else $error("illegal pending read count");

    a_two_beats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && res_count == 2'd2) |-> !res0.last && res1.last)
        else $error("two-beat run marks last wrongly");
`endif

endmodule
